// File: src/rost_pkg.sv
// ----------------------------------------------------------------------------
// rost_pkg: shared definitions for the ray versus oriented box slab test
// Default widths and configuration register indexes.
// ----------------------------------------------------------------------------
package rost_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int AXIS_WIDTH_DEF  = 16;
  localparam int CFG_ADDR_WIDTH  = 3;
  // Registers are 64 bits wide at most; bits above that always read as zero.
  localparam int REG_LIMIT       = 64;
  localparam int NUM_STAGES      = 6;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_AXIS_X       = 3'd0,
    REG_AXIS_Y       = 3'd1,
    REG_AXIS_Z       = 3'd2,
    REG_BOX_POSITION = 3'd3,
    REG_BOUNDS_MIN   = 3'd4,
    REG_BOUNDS_MAX   = 3'd5
  } cfg_reg_t;

endpackage

// File: src/ray_obb_slab_test_unit.sv
// ----------------------------------------------------------------------------
// ray_obb_slab_test_unit: ray versus oriented bounding box slab test
//
//   channel  direction  handshake           content
//   s_*      in         s_tvalid/s_tready   ray origin and direction
//   m_*      out        m_tvalid/m_tready   hit flag
//   cfg_*    in         cfg_we              box registers by index
//
// Six register stages; one item enters per cycle unless the pipeline is full
// and the output stalls. The longest paths are the projection multipliers and
// the pair cross products of the intersection.
// Each stage holds when its successor is full and stalled, so a bubble
// anywhere lets new items in while a result waits at the output.
// Synchronous reset empties the pipeline and loads the unit-axis box.
// ----------------------------------------------------------------------------
module ray_obb_slab_test_unit import rost_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = AXIS_WIDTH_DEF,
  localparam int IN_BITS    = 3 * COORD_WIDTH + 3 * AXIS_WIDTH,
  localparam int IN_WIDTH   = ((IN_BITS + 7) / 8) * 8,
  localparam int CFG_WIDTH  = 3 * ((COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
  input  logic [IN_WIDTH-1:0]        s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // hit, zero fill
  output logic [7:0]                 m_tdata,
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_WIDTH-1:0]       cfg_wdata
);

  localparam int NW = AXIS_WIDTH + COORD_WIDTH + 4;
  localparam int DW = 2 * AXIS_WIDTH + 2;

  logic [3*AXIS_WIDTH-1:0]  axis_x, axis_y, axis_z;
  logic [3*COORD_WIDTH-1:0] box_position, bounds_min, bounds_max;

  logic [NUM_STAGES:1]   valid;
  logic [NUM_STAGES+1:1] rdy;

  logic signed [NW-1:0] an [3];
  logic signed [NW-1:0] bn [3];
  logic signed [DW-1:0] den [3];
  logic [2:0]           bounded;
  logic                 ok;
  logic                 hit;

  always_comb begin
    rdy[NUM_STAGES+1] = m_tready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= (k == 1) ? s_tvalid : valid[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = valid[NUM_STAGES];
  assign m_tdata  = {7'b0, hit};

  rost_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .AXIS_WIDTH  (AXIS_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z),
    .box_position (box_position),
    .bounds_min   (bounds_min),
    .bounds_max   (bounds_max)
  );

  rost_slab #(
    .COORD_WIDTH (COORD_WIDTH),
    .AXIS_WIDTH  (AXIS_WIDTH)
  ) u_slab (
    .clk          (clk),
    .load         (rdy[4:1]),
    .origin       (s_tdata[3*COORD_WIDTH-1:0]),
    .dir          (s_tdata[IN_BITS-1:3*COORD_WIDTH]),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z),
    .box_position (box_position),
    .bounds_min   (bounds_min),
    .bounds_max   (bounds_max),
    .an           (an),
    .bn           (bn),
    .den          (den),
    .bounded      (bounded),
    .ok           (ok)
  );

  rost_isect #(
    .COORD_WIDTH (COORD_WIDTH),
    .AXIS_WIDTH  (AXIS_WIDTH)
  ) u_isect (
    .clk     (clk),
    .load    (rdy[6:5]),
    .an      (an),
    .bn      (bn),
    .den     (den),
    .bounded (bounded),
    .ok      (ok),
    .hit     (hit)
  );

endmodule

// File: src/rost_cfg.sv
// ----------------------------------------------------------------------------
// rost_cfg: box configuration registers
// Holds the three box axes, the box position and the local bounds.
// ----------------------------------------------------------------------------
module rost_cfg import rost_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = AXIS_WIDTH_DEF,
  parameter int CFG_WIDTH   = 3 * COORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  logic [CFG_WIDTH-1:0]        cfg_wdata,
  output logic [3*AXIS_WIDTH-1:0]     axis_x,
  output logic [3*AXIS_WIDTH-1:0]     axis_y,
  output logic [3*AXIS_WIDTH-1:0]     axis_z,
  output logic [3*COORD_WIDTH-1:0]    box_position,
  output logic [3*COORD_WIDTH-1:0]    bounds_min,
  output logic [3*COORD_WIDTH-1:0]    bounds_max
);

  localparam int AW3 = 3 * AXIS_WIDTH;
  localparam int CW3 = 3 * COORD_WIDTH;

  logic [AW3-1:0] wdata_axis;
  logic [CW3-1:0] wdata_coord;
  logic [AW3-1:0] axis_rst [3];

  // Bits beyond the 64-bit register limit are dropped on every write.
  always_comb begin
    for (int b = 0; b < AW3; b++) begin
      wdata_axis[b] = (b < REG_LIMIT) ? cfg_wdata[b] : 1'b0;
    end
    for (int b = 0; b < CW3; b++) begin
      wdata_coord[b] = (b < REG_LIMIT) ? cfg_wdata[b] : 1'b0;
    end
  end

  // Unit vectors: 1.0 in component k of axis k.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_rst[k] = '0;
      if (k * AXIS_WIDTH + AXIS_WIDTH - 2 < REG_LIMIT) begin
        axis_rst[k][k * AXIS_WIDTH + AXIS_WIDTH - 2] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x       <= axis_rst[0];
      axis_y       <= axis_rst[1];
      axis_z       <= axis_rst[2];
      box_position <= '0;
      bounds_min   <= '0;
      bounds_max   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_AXIS_X:       axis_x       <= wdata_axis;
        REG_AXIS_Y:       axis_y       <= wdata_axis;
        REG_AXIS_Z:       axis_z       <= wdata_axis;
        REG_BOX_POSITION: box_position <= wdata_coord;
        REG_BOUNDS_MIN:   bounds_min   <= wdata_coord;
        REG_BOUNDS_MAX:   bounds_max   <= wdata_coord;
        default: ;
      endcase
    end
  end

endmodule

// File: src/rost_slab.sv
// ----------------------------------------------------------------------------
// rost_slab: per-axis slab interval pipeline
// Four stages: offset, projection products, sums with bounds, interval order.
// ----------------------------------------------------------------------------
module rost_slab import rost_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = AXIS_WIDTH_DEF,
  localparam int NW = AXIS_WIDTH + COORD_WIDTH + 4,
  localparam int DW = 2 * AXIS_WIDTH + 2
) (
  input  logic                         clk,
  input  logic [3:0]                   load,
  input  logic [3*COORD_WIDTH-1:0]     origin,
  input  logic [3*AXIS_WIDTH-1:0]      dir,
  input  logic [3*AXIS_WIDTH-1:0]      axis_x,
  input  logic [3*AXIS_WIDTH-1:0]      axis_y,
  input  logic [3*AXIS_WIDTH-1:0]      axis_z,
  input  logic [3*COORD_WIDTH-1:0]     box_position,
  input  logic [3*COORD_WIDTH-1:0]     bounds_min,
  input  logic [3*COORD_WIDTH-1:0]     bounds_max,
  output logic signed [NW-1:0]         an [3],
  output logic signed [NW-1:0]         bn [3],
  output logic signed [DW-1:0]         den [3],
  output logic [2:0]                   bounded,
  output logic                         ok
);

  localparam int DLT = COORD_WIDTH + 1;
  localparam int PEW = AXIS_WIDTH + DLT;
  localparam int PFW = 2 * AXIS_WIDTH;
  localparam int F   = AXIS_WIDTH - 2;

  logic signed [AXIS_WIDTH-1:0] axc [3][3];
  logic signed [PEW-1:0]        axe [3][3];
  logic signed [PFW-1:0]        axf [3][3];

  logic signed [DLT-1:0]        delta [3];
  logic signed [PFW-1:0]        dir1 [3];
  logic signed [PEW-1:0]        pe [3][3];
  logic signed [PFW-1:0]        pf [3][3];
  logic signed [NW-1:0]         nmin [3];
  logic signed [NW-1:0]         nmax [3];
  logic signed [DW-1:0]         f [3];

  logic signed [NW-1:0]         an_next [3];
  logic signed [NW-1:0]         bn_next [3];
  logic signed [DW-1:0]         den_next [3];
  logic [2:0]                   bounded_next;
  logic [2:0]                   ok_k;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axc[0][i] = signed'(axis_x[i*AXIS_WIDTH +: AXIS_WIDTH]);
      axc[1][i] = signed'(axis_y[i*AXIS_WIDTH +: AXIS_WIDTH]);
      axc[2][i] = signed'(axis_z[i*AXIS_WIDTH +: AXIS_WIDTH]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        axe[k][i] = PEW'(axc[k][i]);
        axf[k][i] = PFW'(axc[k][i]);
      end
    end
  end

  // Stage 1: box position minus origin.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int i = 0; i < 3; i++) begin
        delta[i] <= DLT'(signed'(box_position[i*COORD_WIDTH +: COORD_WIDTH]))
                  - DLT'(signed'(origin[i*COORD_WIDTH +: COORD_WIDTH]));
        dir1[i]  <= PFW'(signed'(dir[i*AXIS_WIDTH +: AXIS_WIDTH]));
      end
    end
  end

  // Stage 2: the nine products for each projection.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pe[k][i] <= axe[k][i] * PEW'(delta[i]);
          pf[k][i] <= axf[k][i] * dir1[i];
        end
      end
    end
  end

  // Stage 3: projected offset plus the scaled bounds, projected direction.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int k = 0; k < 3; k++) begin
        nmin[k] <= NW'(pe[k][0]) + NW'(pe[k][1]) + NW'(pe[k][2])
                 + (NW'(signed'(bounds_min[k*COORD_WIDTH +: COORD_WIDTH])) <<< F);
        nmax[k] <= NW'(pe[k][0]) + NW'(pe[k][1]) + NW'(pe[k][2])
                 + (NW'(signed'(bounds_max[k*COORD_WIDTH +: COORD_WIDTH])) <<< F);
        f[k]    <= DW'(pf[k][0]) + DW'(pf[k][1]) + DW'(pf[k][2]);
      end
    end
  end

  // Stage 4: order entry and exit by the direction sign. A slab parallel to
  // the ray passes only when the origin lies between its planes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (f[k] == '0) begin
        an_next[k]      = nmin[k];
        bn_next[k]      = nmax[k];
        den_next[k]     = f[k];
        bounded_next[k] = 1'b0;
        ok_k[k]         = (nmin[k] <= 0) && (nmax[k] >= 0);
      end else if (f[k] > 0) begin
        an_next[k]      = nmin[k];
        bn_next[k]      = nmax[k];
        den_next[k]     = f[k];
        bounded_next[k] = 1'b1;
        ok_k[k]         = nmin[k] <= nmax[k];
      end else begin
        an_next[k]      = -nmax[k];
        bn_next[k]      = -nmin[k];
        den_next[k]     = -f[k];
        bounded_next[k] = 1'b1;
        ok_k[k]         = nmin[k] <= nmax[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      an      <= an_next;
      bn      <= bn_next;
      den     <= den_next;
      bounded <= bounded_next;
      ok      <= &ok_k;
    end
  end

endmodule

// File: src/rost_isect.sv
// ----------------------------------------------------------------------------
// rost_isect: interval intersection
// The intervals overlap when every entry is at most every exit; each pair of
// bounded axes is checked by an exact cross-multiplied compare.
// ----------------------------------------------------------------------------
module rost_isect import rost_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = AXIS_WIDTH_DEF,
  localparam int NW = AXIS_WIDTH + COORD_WIDTH + 4,
  localparam int DW = 2 * AXIS_WIDTH + 2
) (
  input  logic                  clk,
  input  logic [1:0]            load,
  input  logic signed [NW-1:0]  an [3],
  input  logic signed [NW-1:0]  bn [3],
  input  logic signed [DW-1:0]  den [3],
  input  logic [2:0]            bounded,
  input  logic                  ok,
  output logic                  hit
);

  localparam int DL  = DW / 2;
  localparam int DH  = DW - DL;
  localparam int PLW = NW + DL + 1;
  localparam int PHW = NW + DH + 1;
  localparam int PW  = NW + DW + 1;

  logic [2:0] bounded5;
  logic       ok5;
  logic [8:0] pass;

  for (genvar j = 0; j < 3; j++) begin : g_entry
    for (genvar k = 0; k < 3; k++) begin : g_exit
      if (j == k) begin : g_self
        assign pass[j*3+k] = 1'b1;
      end else begin : g_pair
        logic signed [PLW-1:0] xl, yl;
        logic signed [PHW-1:0] xh, yh;
        logic signed [PW-1:0]  x, y;

        // Stage 5: the denominators are split in halves for the multipliers.
        always_ff @(posedge clk) begin
          if (load[0]) begin
            xl <= PLW'(an[j]) * PLW'(signed'({1'b0, den[k][DL-1:0]}));
            xh <= PHW'(an[j]) * PHW'(signed'({1'b0, den[k][DW-1:DL]}));
            yl <= PLW'(bn[k]) * PLW'(signed'({1'b0, den[j][DL-1:0]}));
            yh <= PHW'(bn[k]) * PHW'(signed'({1'b0, den[j][DW-1:DL]}));
          end
        end

        assign x = PW'(xl) + (PW'(xh) <<< DL);
        assign y = PW'(yl) + (PW'(yh) <<< DL);
        assign pass[j*3+k] = !(bounded5[j] && bounded5[k]) || (x <= y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      bounded5 <= bounded;
      ok5      <= ok;
    end
  end

  // Stage 6: result register.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      hit <= ok5 && (&pass);
    end
  end

endmodule

// File: src/rost_checker.sv
// ----------------------------------------------------------------------------
// rost_checker: port-level checks for the slab test unit
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module rost_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // An empty or draining output never blocks the input.
  assert property (@(posedge clk) disable iff (rst) (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output can move");

  // The fill bits of a result stay zero.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("nonzero fill bits in result");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind ray_obb_slab_test_unit rost_checker u_rost_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
